FILE: design/mlmd_pkg.sv
// ----------------------------------------------------------------------------
// mlmd_pkg
// Types and constants shared by the message deframer and its channels.
// ----------------------------------------------------------------------------
package mlmd_pkg;

  localparam logic [15:0] MAGIC_WORD = 16'h41FE;

  localparam int TYPE_W   = 16;
  localparam int LEN_W    = 31;
  localparam int SLOT_W   = 2;
  localparam int COUNT_W  = 3;
  localparam int REG_IDX_W = 8;
  localparam int WIN_W    = 56;
  localparam int FILL_W   = 3;

  // Register map
  localparam logic [REG_IDX_W-1:0] REG_HANDLER_COUNT  = 8'd0;
  localparam logic [REG_IDX_W-1:0] REG_HANDLER_TYPE0  = 8'd1;
  localparam int                   NUM_TYPE_REGS      = 4;

  localparam logic [FILL_W-1:0] FILL_FULL = 3'd7;

  typedef enum logic [1:0] {
    KIND_BODY  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_NOISE = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] rx_byte;
  } rx_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [TYPE_W-1:0]  msg_type;
    logic [7:0]         payload_byte;
    logic               last;
    logic [LEN_W-1:0]   msg_length;
    logic               handler_found;
    logic [SLOT_W-1:0]  handler_index;
  } res_item_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0] reg_index;
    logic [TYPE_W-1:0]    wr_data;
  } cfg_wr_t;

endpackage

FILE: design/mlmd_chan_if.sv
// ----------------------------------------------------------------------------
// mlmd_chan_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface mlmd_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: design/magic_length_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// magic_length_message_deframer_unit
// Hunts for a magic/type/length header in a byte stream, forwards body bytes
// tagged with type and handler match, reports noise bytes and empty messages.
// A result is registered and valid in the cycle after the byte that causes it.
// Throughput: one byte per cycle; the single result register frees itself
// in the cycle it is taken, so input stalls only on output backpressure.
// Reset: asynchronous, active low; clears the header window, the body counter
// and the configuration registers. No clearing pass is needed.
// ----------------------------------------------------------------------------
module magic_length_message_deframer_unit #(
  parameter int NUM_HANDLERS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mlmd_chan_if.sink   rx_i,
  mlmd_chan_if.source res_o,
  mlmd_chan_if.sink   cfg_i
);

  // Configuration
  logic [mlmd_pkg::COUNT_W-1:0] count_q;
  logic [mlmd_pkg::TYPE_W-1:0]  htype_q [NUM_HANDLERS];

  // Deframer state
  logic [mlmd_pkg::WIN_W-1:0]   win_q, win_d;
  logic [mlmd_pkg::FILL_W-1:0]  fill_q, fill_d;
  logic                         in_body_q, in_body_d;
  logic [mlmd_pkg::LEN_W-1:0]   rem_q, rem_d;
  logic [mlmd_pkg::TYPE_W-1:0]  type_q, type_d;
  logic [mlmd_pkg::LEN_W-1:0]   len_q, len_d;
  logic                         found_q, found_d;
  logic [mlmd_pkg::SLOT_W-1:0]  slot_q, slot_d;

  // Result register
  logic                         out_valid_q;
  mlmd_pkg::res_item_t          res_q, res_d;
  logic                         emit;

  logic                         in_acc, res_acc;
  logic [mlmd_pkg::WIN_W+7:0]   w;
  logic [mlmd_pkg::TYPE_W-1:0]  hdr_type;
  logic [mlmd_pkg::LEN_W-1:0]   hdr_len;
  logic                         lk_found;
  logic [mlmd_pkg::SLOT_W-1:0]  lk_slot;
  logic [mlmd_pkg::LEN_W-1:0]   rem_dec;

  assign cfg_i.ready = 1'b1;
  assign rx_i.ready  = !out_valid_q || res_o.ready;
  assign in_acc      = rx_i.valid && rx_i.ready;
  assign res_acc     = res_o.valid && res_o.ready;
  assign res_o.valid = out_valid_q;
  assign res_o.data  = res_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < NUM_HANDLERS; i++) htype_q[i] <= '0;
    end else if (cfg_i.valid) begin
      if (cfg_i.data.reg_index == mlmd_pkg::REG_HANDLER_COUNT) begin
        count_q <= cfg_i.data.wr_data[mlmd_pkg::COUNT_W-1:0];
      end
      for (int i = 0; i < NUM_HANDLERS; i++) begin
        if (i < mlmd_pkg::NUM_TYPE_REGS &&
            cfg_i.data.reg_index ==
              mlmd_pkg::REG_HANDLER_TYPE0 + mlmd_pkg::REG_IDX_W'(i)) begin
          htype_q[i] <= cfg_i.data.wr_data;
        end
      end
    end
  end

  assign w        = {win_q, rx_i.data.rx_byte};
  assign hdr_type = w[47:32];
  assign hdr_len  = w[31] ? '0 : w[30:0];
  assign rem_dec  = rem_q - mlmd_pkg::LEN_W'(1);

  // First matching handler slot among the enabled ones
  always_comb begin
    lk_found = 1'b0;
    lk_slot  = '0;
    for (int i = NUM_HANDLERS - 1; i >= 0; i--) begin
      if (int'(count_q) > i && htype_q[i] == hdr_type) begin
        lk_found = 1'b1;
        lk_slot  = mlmd_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    win_d     = win_q;
    fill_d    = fill_q;
    in_body_d = in_body_q;
    rem_d     = rem_q;
    type_d    = type_q;
    len_d     = len_q;
    found_d   = found_q;
    slot_d    = slot_q;
    emit      = 1'b0;
    res_d     = '0;
    if (in_body_q) begin
      rem_d               = rem_dec;
      emit                = 1'b1;
      res_d.kind          = mlmd_pkg::KIND_BODY;
      res_d.msg_type      = type_q;
      res_d.payload_byte  = rx_i.data.rx_byte;
      res_d.last          = (rem_dec == '0);
      res_d.msg_length    = len_q;
      res_d.handler_found = found_q;
      res_d.handler_index = slot_q;
      if (rem_dec == '0) begin
        in_body_d = 1'b0;
        fill_d    = '0;
        win_d     = '0;
      end
    end else if (fill_q != mlmd_pkg::FILL_FULL) begin
      win_d  = w[mlmd_pkg::WIN_W-1:0];
      fill_d = fill_q + mlmd_pkg::FILL_W'(1);
    end else if (w[63:48] != mlmd_pkg::MAGIC_WORD) begin
      // slide by one byte, oldest byte is noise
      win_d              = w[mlmd_pkg::WIN_W-1:0];
      emit               = 1'b1;
      res_d.kind         = mlmd_pkg::KIND_NOISE;
      res_d.payload_byte = w[63:56];
    end else begin
      type_d  = hdr_type;
      len_d   = hdr_len;
      found_d = lk_found;
      slot_d  = lk_slot;
      win_d   = '0;
      fill_d  = '0;
      if (hdr_len == '0) begin
        emit                = 1'b1;
        res_d.kind          = mlmd_pkg::KIND_EMPTY;
        res_d.msg_type      = hdr_type;
        res_d.last          = 1'b1;
        res_d.handler_found = lk_found;
        res_d.handler_index = lk_slot;
      end else begin
        rem_d     = hdr_len;
        in_body_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      fill_q      <= '0;
      in_body_q   <= 1'b0;
      rem_q       <= '0;
      type_q      <= '0;
      len_q       <= '0;
      found_q     <= 1'b0;
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        win_q     <= win_d;
        fill_q    <= fill_d;
        in_body_q <= in_body_d;
        rem_q     <= rem_d;
        type_q    <= type_d;
        len_q     <= len_d;
        found_q   <= found_d;
        slot_q    <= slot_d;
      end
      if (in_acc) begin
        out_valid_q <= emit;
      end else if (res_acc) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && emit) begin
      res_q <= res_d;
    end
  end

  // Checks
  a_body_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> rem_q != '0)
    else $error("body active with zero bytes remaining");

  a_body_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_body_q) |=> out_valid_q && res_q.kind == mlmd_pkg::KIND_BODY)
    else $error("body byte produced no result");

  a_body_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_body_q && rem_q == mlmd_pkg::LEN_W'(1)) |=>
      !in_body_q && res_q.last)
    else $error("message end not marked");

  a_noise_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == mlmd_pkg::KIND_NOISE) |->
      !res_q.last && res_q.msg_length == '0 && !res_q.handler_found)
    else $error("noise result carries message fields");

  a_empty_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.kind == mlmd_pkg::KIND_EMPTY) |->
      res_q.last && res_q.msg_length == '0)
    else $error("malformed empty-message result");

endmodule

FILE: test/mlmd_deframe_checker.sv
// ----------------------------------------------------------------------------
// mlmd_deframe_checker
// Watches the byte, result and register channels of the message deframer.
// Keeps its own header window, body counter and handler table, works out the
// result, if any, of every accepted byte and compares it with the next result taken.
// ----------------------------------------------------------------------------
module mlmd_deframe_checker #(
  parameter int N_HANDLERS = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  input  logic                rx_ready_i,
  input  mlmd_pkg::rx_item_t  rx_data_i,
  input  logic                res_valid_i,
  input  logic                res_ready_i,
  input  mlmd_pkg::res_item_t res_data_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  mlmd_pkg::cfg_wr_t   cfg_data_i,
  output int                  pending_o,
  output int                  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [mlmd_pkg::COUNT_W-1:0] table_count;
  logic [mlmd_pkg::TYPE_W-1:0]  table_type [N_HANDLERS];

  logic [63:0]                  hdr_win;
  logic [3:0]                   win_fill;
  logic                         body_active;
  logic [mlmd_pkg::LEN_W-1:0]   body_left;
  logic [mlmd_pkg::TYPE_W-1:0]  cur_type;
  logic [mlmd_pkg::LEN_W-1:0]   cur_len;
  logic                         hit;
  logic [mlmd_pkg::SLOT_W-1:0]  hit_slot;

  mlmd_pkg::res_item_t deframed_q[$];
  int                  bad_results;

  task automatic deframe_byte(input logic [7:0] b);
    mlmd_pkg::res_item_t r;
    logic [31:0] raw;
    int limit;
    r = '0;
    if (body_active) begin
      body_left       = body_left - 1'b1;
      r.kind          = mlmd_pkg::KIND_BODY;
      r.msg_type      = cur_type;
      r.payload_byte  = b;
      r.last          = (body_left == '0);
      r.msg_length    = cur_len;
      r.handler_found = hit;
      r.handler_index = hit_slot;
      deframed_q.push_back(r);
      if (body_left == '0) begin
        body_active = 1'b0;
        win_fill    = '0;
        hdr_win     = '0;
      end
    end else begin
      hdr_win = {hdr_win[55:0], b};
      if (win_fill < 4'd8) win_fill = win_fill + 1'b1;
      if (win_fill == 4'd8) begin
        if (hdr_win[63:48] != mlmd_pkg::MAGIC_WORD) begin
          r.kind          = mlmd_pkg::KIND_NOISE;
          r.payload_byte  = hdr_win[63:56];
          hdr_win[63:56]  = 8'h00;
          win_fill        = 4'd7;
          deframed_q.push_back(r);
        end else begin
          cur_type = hdr_win[47:32];
          raw      = hdr_win[31:0];
          cur_len  = raw[31] ? '0 : raw[mlmd_pkg::LEN_W-1:0];
          // match is latched here; later table writes do not touch it
          limit    = (table_count > N_HANDLERS) ? N_HANDLERS : table_count;
          hit      = 1'b0;
          hit_slot = '0;
          for (int i = 0; i < N_HANDLERS; i++) begin
            if (!hit && i < limit && table_type[i] == cur_type) begin
              hit      = 1'b1;
              hit_slot = i[mlmd_pkg::SLOT_W-1:0];
            end
          end
          hdr_win  = '0;
          win_fill = '0;
          if (cur_len == '0) begin
            r.kind          = mlmd_pkg::KIND_EMPTY;
            r.msg_type      = cur_type;
            r.last          = 1'b1;
            r.handler_found = hit;
            r.handler_index = hit_slot;
            deframed_q.push_back(r);
          end else begin
            body_left   = cur_len;
            body_active = 1'b1;
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    mlmd_pkg::res_item_t want;
    if (!rst_ni) begin
      table_count = '0;
      for (int i = 0; i < N_HANDLERS; i++) table_type[i] = '0;
      hdr_win     = '0;
      win_fill    = '0;
      body_active = 1'b0;
      body_left   = '0;
      cur_type    = '0;
      cur_len     = '0;
      hit         = 1'b0;
      hit_slot    = '0;
      deframed_q.delete();
      bad_results = 0;
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      // results leave only after their byte has been taken, so check before predicting
      if (res_valid_i && res_ready_i) begin
        if (deframed_q.size() == 0) begin
          if (bad_results < 10)
            $display("%t unexpected result: kind=%0d type=%h byte=%h last=%0d",
                     $time, res_data_i.kind, res_data_i.msg_type,
                     res_data_i.payload_byte, res_data_i.last,
                     " len=%0d found=%0d slot=%0d",
                     res_data_i.msg_length, res_data_i.handler_found,
                     res_data_i.handler_index);
          bad_results++;
        end else begin
          want = deframed_q.pop_front();
          if (res_data_i.kind !== want.kind || res_data_i.msg_type !== want.msg_type ||
              res_data_i.payload_byte !== want.payload_byte ||
              res_data_i.last !== want.last ||
              res_data_i.msg_length !== want.msg_length ||
              res_data_i.handler_found !== want.handler_found ||
              res_data_i.handler_index !== want.handler_index) begin
            if (bad_results < 10) begin
              $display("%t mismatch: exp kind=%0d type=%h byte=%h last=%0d",
                       $time, want.kind, want.msg_type, want.payload_byte, want.last,
                       " len=%0d found=%0d slot=%0d",
                       want.msg_length, want.handler_found, want.handler_index);
              $display("%t           got kind=%0d type=%h byte=%h last=%0d",
                       $time, res_data_i.kind, res_data_i.msg_type,
                       res_data_i.payload_byte, res_data_i.last,
                       " len=%0d found=%0d slot=%0d",
                       res_data_i.msg_length, res_data_i.handler_found,
                       res_data_i.handler_index);
            end
            bad_results++;
          end
        end
      end
      // a byte sees the table as it stood before this edge
      if (rx_valid_i && rx_ready_i) deframe_byte(rx_data_i.rx_byte);
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_data_i.reg_index == mlmd_pkg::REG_HANDLER_COUNT)
          table_count = cfg_data_i.wr_data[mlmd_pkg::COUNT_W-1:0];
        else if (cfg_data_i.reg_index >= mlmd_pkg::REG_HANDLER_TYPE0 &&
                 cfg_data_i.reg_index < mlmd_pkg::REG_HANDLER_TYPE0 + N_HANDLERS &&
                 cfg_data_i.reg_index <
                   mlmd_pkg::REG_HANDLER_TYPE0 + mlmd_pkg::NUM_TYPE_REGS)
          table_type[cfg_data_i.reg_index - mlmd_pkg::REG_HANDLER_TYPE0] =
            cfg_data_i.wr_data;
      end
      pending_o    <= deframed_q.size();
      fail_count_o <= bad_results;
    end
  end

endmodule

FILE: test/tb_magic_length_message_deframer_unit.sv
// ----------------------------------------------------------------------------
// tb_magic_length_message_deframer_unit
// Feeds the deframer directed frames, then random messages mixed with noise
// and corrupted headers over several handler table settings, with random
// stalls on both sides. Checking is done by mlmd_deframe_checker.
// ----------------------------------------------------------------------------
module tb_magic_length_message_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_HANDLERS    = 4;
  localparam int PHASE_BYTES   = 235;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int TIMEOUT_NS    = 2_000_000;

  localparam logic [mlmd_pkg::REG_IDX_W-1:0] REG_PAST_TABLE =
    mlmd_pkg::REG_HANDLER_TYPE0 + mlmd_pkg::REG_IDX_W'(mlmd_pkg::NUM_TYPE_REGS);
  localparam logic [mlmd_pkg::REG_IDX_W-1:0] REG_INDEX_MAX  = '1;

  logic clk_i;
  logic rst_ni;
  int   pending;
  int   fail_count;

  bit                          idle_on;
  int                          bytes_sent;
  logic [7:0]                  last_junk;
  logic [mlmd_pkg::TYPE_W-1:0] slot_type [N_HANDLERS];

  mlmd_chan_if #(.T(mlmd_pkg::rx_item_t))  rx_if  ();
  mlmd_chan_if #(.T(mlmd_pkg::res_item_t)) res_if ();
  mlmd_chan_if #(.T(mlmd_pkg::cfg_wr_t))   cfg_if ();

  magic_length_message_deframer_unit #(
    .NUM_HANDLERS(N_HANDLERS)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .rx_i  (rx_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  mlmd_deframe_checker #(
    .N_HANDLERS(N_HANDLERS)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_if.valid),
    .rx_ready_i  (rx_if.ready),
    .rx_data_i   (rx_if.data),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_data_i  (res_if.data),
    .cfg_valid_i (cfg_if.valid),
    .cfg_ready_i (cfg_if.ready),
    .cfg_data_i  (cfg_if.data),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      res_if.ready <= rst_ni && (!idle_on || $urandom_range(99) >= 25);
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Verification failed");
    $finish;
  end

  task automatic push_byte(input logic [7:0] b);
    while (idle_on && $urandom_range(99) < 25) begin
      rx_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rx_if.valid        <= 1'b1;
    rx_if.data.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_sent++;
  endtask

  // noise that never forms the magic pair, so no false header swallows the stream
  task automatic push_junk(input logic [7:0] b);
    if (last_junk == mlmd_pkg::MAGIC_WORD[15:8] && b == mlmd_pkg::MAGIC_WORD[7:0]) b = ~b;
    last_junk = b;
    push_byte(b);
  endtask

  task automatic send_header(input logic [mlmd_pkg::TYPE_W-1:0] msg_type,
                             input logic [31:0] len);
    last_junk = 8'h00;
    push_byte(mlmd_pkg::MAGIC_WORD[15:8]);
    push_byte(mlmd_pkg::MAGIC_WORD[7:0]);
    push_byte(msg_type[15:8]);
    push_byte(msg_type[7:0]);
    push_byte(len[31:24]);
    push_byte(len[23:16]);
    push_byte(len[15:8]);
    push_byte(len[7:0]);
  endtask

  task automatic settle();
    rx_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mlmd_pkg::REG_IDX_W-1:0] idx,
                           input logic [mlmd_pkg::TYPE_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{reg_index: idx, wr_data: val};
    do @(posedge clk_i); while (!cfg_if.ready);
  endtask

  task automatic load_table(input logic [mlmd_pkg::COUNT_W-1:0] count);
    logic [mlmd_pkg::TYPE_W-1:0] val;
    val                          = mlmd_pkg::TYPE_W'($urandom);
    val[mlmd_pkg::COUNT_W-1:0]   = count;
    write_reg(mlmd_pkg::REG_HANDLER_COUNT, val);
    for (int i = 0; i < N_HANDLERS; i++)
      write_reg(mlmd_pkg::REG_HANDLER_TYPE0 + mlmd_pkg::REG_IDX_W'(i), slot_type[i]);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic shuffle_table();
    for (int i = 0; i < N_HANDLERS; i++) slot_type[i] = mlmd_pkg::TYPE_W'($urandom);
  endtask

  task automatic run_traffic(input int n);
    int                          stop_at;
    int                          sel;
    logic [mlmd_pkg::TYPE_W-1:0] hdr_type;
    logic [31:0]                 hdr_len;
    stop_at = bytes_sent + n;
    while (bytes_sent < stop_at) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        repeat ($urandom_range(1, 6)) push_junk(8'($urandom));
      end else if (sel < 13) begin
        // header with a corrupted magic byte
        if ($urandom_range(1)) begin
          push_junk(mlmd_pkg::MAGIC_WORD[15:8]);
          push_junk(8'($urandom));
        end else begin
          push_junk(8'($urandom));
          push_junk(mlmd_pkg::MAGIC_WORD[7:0]);
        end
        repeat (6) push_junk(8'($urandom));
      end else begin
        sel = $urandom_range(99);
        if (sel < 50)      hdr_type = slot_type[$urandom_range(N_HANDLERS-1)];
        else if (sel < 55) hdr_type = '0;
        else if (sel < 60) hdr_type = '1;
        else               hdr_type = mlmd_pkg::TYPE_W'($urandom);
        sel = $urandom_range(99);
        if (sel < 15)      hdr_len = '0;
        else if (sel < 25) hdr_len = $urandom | 32'h8000_0000;
        else if (sel < 95) hdr_len = $urandom_range(1, 12);
        else               hdr_len = $urandom_range(13, 40);
        send_header(hdr_type, hdr_len);
        if (!hdr_len[31]) repeat (hdr_len) push_byte(8'($urandom));
      end
    end
  endtask

  initial begin
    int wait_cycles;
    rx_if.valid  <= 1'b0;
    rx_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    rst_ni     = 1'b0;
    idle_on    = 1'b1;
    bytes_sent = 0;
    last_junk  = 8'h00;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset table: nothing matches
    push_byte(8'h00);
    push_byte(8'hFF);
    send_header(16'hFFFF, 32'd0);
    send_header(16'h0000, 32'h8000_0000);
    send_header(16'h1357, 32'd1);
    push_byte(8'hFF);
    settle();

    slot_type = '{16'h0000, 16'hFFFF, 16'h1234, 16'hABCD};
    load_table(3'd4);
    run_traffic(PHASE_BYTES);
    settle();

    // count above table size, duplicate entry
    slot_type = '{16'h5555, 16'hAAAA, 16'h5555, 16'h00FF};
    load_table(3'd7);
    run_traffic(PHASE_BYTES);
    settle();

    write_reg(REG_PAST_TABLE, mlmd_pkg::TYPE_W'($urandom));
    write_reg(REG_INDEX_MAX, mlmd_pkg::TYPE_W'($urandom));
    shuffle_table();
    load_table(3'd0);
    run_traffic(PHASE_BYTES);
    settle();

    idle_on = 1'b0;
    shuffle_table();
    load_table(3'd2);
    run_traffic(PHASE_BYTES);

    // table changes in the middle of a body
    send_header(slot_type[0], 32'd5);
    push_byte(8'($urandom));
    push_byte(8'($urandom));
    settle();
    idle_on = 1'b1;
    shuffle_table();
    load_table(3'd1);
    repeat (3) push_byte(8'($urandom));
    run_traffic(PHASE_BYTES);
    settle();

    shuffle_table();
    load_table(3'd3);
    run_traffic(PHASE_BYTES);

    // largest length: the body never completes within the run
    send_header(slot_type[1], 32'h7FFF_FFFF);
    repeat (30) push_byte(8'($urandom));
    rx_if.valid <= 1'b0;

    wait_cycles = 0;
    do begin
      @(posedge clk_i);
      wait_cycles++;
    end while (pending != 0 && wait_cycles < DRAIN_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
